// File: rtl/pbba_pkg.sv
`timescale 1ns / 1ps
package pbba_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_BIN_DEF    = 16;

  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd40;
  localparam logic [4:0] BIN_FACTOR_RST   = 5'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BIN_FACTOR   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] low_sample;
    logic signed [15:0] high_sample;
    logic signed [15:0] max_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        bin_index;
    logic signed [15:0] avg_low;
    logic signed [15:0] avg_high;
    logic [14:0]        peak;
    logic [8:0]         pixel_count;
    logic               frame_done;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_UPD   = 3'd2,
    ST_DIV   = 3'd3,
    ST_LOAD  = 3'd4
  } state_t;

  typedef struct packed {
    logic restart;
    logic clr;
    logic accept;
    logic upd;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic emit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/pbba_ram.sv
`timescale 1ns / 1ps
module pbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pbba_div.sv
`timescale 1ns / 1ps
module pbba_div #(
  parameter int NW = 24,
  parameter int DW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic [15:0]          quotient
);

  localparam int KW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   trial;
  logic [NW-1:0] q_signed;

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, q_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(NW);
      q_nxt    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      rem_nxt  = '0;
      d_nxt    = divisor;
      neg_nxt  = dividend[NW-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = DW'(trial - {1'b0, d_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = DW'(trial);
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? NW'(-q_r) : q_r;
  assign quotient = q_signed[15:0];
  assign done     = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without running");

endmodule

// File: rtl/pbba_ctrl.sv
`timescale 1ns / 1ps
module pbba_ctrl
  import pbba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    if (cfg_wr) begin
      cmd.restart = 1'b1;
      state_nxt   = ST_CLEAR;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          cmd.clr = 1'b1;
          if (sts.clr_last) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = ST_UPD;
          end
        end
        ST_UPD: begin
          cmd.upd = 1'b1;
          if (sts.emit) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_DIV: begin
          if (sts.div_done) begin
            state_nxt = ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (sts.out_free) begin
            cmd.load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_CLEAR;
        end
      endcase
    end
  end

  a_accept_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.upd)
    else $error("accepted word not followed by accumulator update");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && cmd.clr))
    else $error("input taken during clearing pass");

  a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_LOAD))
    else $error("result loaded outside load state");

endmodule

// File: rtl/pbba_dp.sv
`timescale 1ns / 1ps
module pbba_dp
  import pbba_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_BIN    = MAX_BIN_DEF,
  localparam int XW = $clog2(MAX_WIDTH + 1),
  localparam int YW = $clog2(MAX_HEIGHT + 1),
  localparam int BW = $clog2(MAX_BIN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [XW-1:0] w_eff,
  input  logic [YW-1:0] h_eff,
  input  logic [BW-1:0] b_eff,
  input  in_word_t      in_data,
  input  logic          out_ready,
  output logic          out_valid,
  output out_word_t     out_data,
  input  cmd_t          cmd,
  output sts_t          sts
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ACC_W = 16 + 2 * $clog2(MAX_BIN);
  localparam int CW    = $clog2(MAX_BIN * MAX_BIN + 1);
  localparam int RW    = 2 * ACC_W + 15;

  logic [XW-1:0] x_r, bc_r;
  logic [YW-1:0] y_r;
  logic [BW-1:0] xin_r, yin_r;
  logic [15:0]   base_r;
  logic [AW-1:0] clr_r;

  logic signed [15:0] lo_r, hi_r, mx_r;
  logic [AW-1:0] wa_r;
  logic          emit_r;
  logic [15:0]   idx_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [14:0]   pk_res_r;
  logic          out_valid_r;
  out_word_t     out_data_r;

  logic last_x, last_y, xin_end, yin_end, row_end, col_end;

  assign last_x  = (x_r + XW'(1)) == w_eff;
  assign last_y  = (y_r + YW'(1)) == h_eff;
  assign xin_end = xin_r == (b_eff - BW'(1));
  assign yin_end = yin_r == (b_eff - BW'(1));
  assign col_end = last_x || xin_end;
  assign row_end = last_y || yin_end;

  // Raster counters; the bin row base grows by the bins per row at each bin row end.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      x_r    <= '0;
      bc_r   <= '0;
      xin_r  <= '0;
      y_r    <= '0;
      yin_r  <= '0;
      base_r <= '0;
      clr_r  <= '0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.accept) begin
        if (last_x) begin
          x_r   <= '0;
          bc_r  <= '0;
          xin_r <= '0;
          y_r   <= last_y ? '0 : y_r + 1'b1;
          yin_r <= row_end ? '0 : yin_r + 1'b1;
          if (last_y) begin
            base_r <= '0;
          end else if (row_end) begin
            base_r <= base_r + 16'(bc_r) + 16'd1;
          end
        end else begin
          x_r   <= x_r + 1'b1;
          xin_r <= xin_end ? '0 : xin_r + 1'b1;
          bc_r  <= xin_end ? bc_r + 1'b1 : bc_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lo_r   <= in_data.low_sample;
      hi_r   <= in_data.high_sample;
      mx_r   <= in_data.max_sample;
      wa_r   <= bc_r[AW-1:0];
      emit_r <= col_end && row_end;
      idx_r  <= base_r + 16'(bc_r);
      cnt_r  <= (CW'(xin_r) + CW'(1)) * (CW'(yin_r) + CW'(1));
      done_r <= last_x && last_y;
    end
  end

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;
  logic signed [ACC_W-1:0] rd_lo, rd_hi, lo_sum, hi_sum;
  logic [14:0]       rd_pk, pk_new;

  assign rd_lo  = ram_rdata[RW-1 -: ACC_W];
  assign rd_hi  = ram_rdata[ACC_W+14 -: ACC_W];
  assign rd_pk  = ram_rdata[14:0];
  assign lo_sum = rd_lo + ACC_W'(lo_r);
  assign hi_sum = rd_hi + ACC_W'(hi_r);
  assign pk_new = (mx_r > $signed({1'b0, rd_pk})) ? mx_r[14:0] : rd_pk;

  always_comb begin
    ram_we    = cmd.clr || cmd.upd;
    ram_waddr = cmd.clr ? clr_r : wa_r;
    ram_wdata = (cmd.clr || emit_r) ? '0 : {lo_sum, hi_sum, pk_new};
  end

  pbba_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (bc_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      pk_res_r <= pk_new;
    end
  end

  logic        div_done_lo, div_done_hi;
  logic [15:0] q_lo, q_hi;

  pbba_div #(
    .NW (ACC_W),
    .DW (CW)
  ) u_div_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lo_sum),
    .divisor  (cnt_r),
    .done     (div_done_lo),
    .quotient (q_lo)
  );

  pbba_div #(
    .NW (ACC_W),
    .DW (CW)
  ) u_div_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (hi_sum),
    .divisor  (cnt_r),
    .done     (div_done_hi),
    .quotient (q_hi)
  );

  // The output register lets the next word in while this result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load) begin
      out_data_r.bin_index   <= idx_r;
      out_data_r.avg_low     <= q_lo;
      out_data_r.avg_high    <= q_hi;
      out_data_r.peak        <= pk_res_r;
      out_data_r.pixel_count <= 9'(cnt_r);
      out_data_r.frame_done  <= done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.clr_last = clr_r == AW'(MAX_WIDTH - 1);
    sts.emit     = emit_r;
    sts.div_done = div_done_lo;
    sts.out_free = !out_valid_r || out_ready;
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_lo == div_done_hi)
    else $error("dividers out of step");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// File: rtl/pixel_block_binning_average_max_unit.sv
`timescale 1ns / 1ps
// A word that closes no bin is read from the bin column RAM, then written back updated. A word
// that closes a bin also starts the bit-serial divider on its ACC_W-bit sums, ACC_W = 16 +
// 2*clog2(MAX_BIN) (24 by default); no new word is taken until the result is loaded.
// Reset is synchronous; after reset and after every write to a used register the accumulator
// RAM is cleared entry by entry over all MAX_WIDTH entries, during which in_ready is low.
module pixel_block_binning_average_max_unit
  import pbba_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_BIN    = MAX_BIN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = $clog2(MAX_BIN + 1);

  logic [8:0] fw_r, fh_r;
  logic [4:0] bf_r;
  reg_idx_t   idx;
  logic       wr_strobe, cfg_wr;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_strobe  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_wr     = wr_strobe && (idx != REG_UNUSED);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
      bf_r <= BIN_FACTOR_RST;
    end else if (wr_strobe) begin
      case (idx)
        REG_FRAME_WIDTH:  fw_r <= cfg_pwdata[8:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_pwdata[8:0];
        REG_BIN_FACTOR:   bf_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  cfg_prdata = {23'd0, fw_r};
      REG_FRAME_HEIGHT: cfg_prdata = {23'd0, fh_r};
      REG_BIN_FACTOR:   cfg_prdata = {27'd0, bf_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Registers keep the written bits; the datapath sees them saturated to the legal range.
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [BW-1:0] b_eff;

  assign w_eff = (fw_r == '0) ? XW'(1) :
                 ((32'(fw_r) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(fw_r));
  assign h_eff = (fh_r == '0) ? YW'(1) :
                 ((32'(fh_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(fh_r));
  assign b_eff = (bf_r == '0) ? BW'(1) :
                 ((32'(bf_r) > MAX_BIN) ? BW'(MAX_BIN) : BW'(bf_r));

  cmd_t cmd;
  sts_t sts;

  pbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbba_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BIN    (MAX_BIN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .b_eff     (b_eff),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: tb/sv/pbba_bin_checker.sv
`timescale 1ns / 1ps
module pbba_bin_checker
  import pbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          bins_seen
);

  out_word_t expected_bins[$];

  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [4:0] bin_reg;

  int col_pos;
  int row_pos;
  int low_sum[MAX_WIDTH_DEF];
  int high_sum[MAX_WIDTH_DEF];
  int peak_max[MAX_WIDTH_DEF];

  function void restart_frame();
    col_pos = 0;
    row_pos = 0;
    foreach (low_sum[i]) begin
      low_sum[i]  = 0;
      high_sum[i] = 0;
      peak_max[i] = 0;
    end
  endfunction

  function int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function void bin_pixel(in_word_t d);
    int w, h, b, x, y, bc, br, cw, ch, cnt, lo_avg, hi_avg;
    bit last_x, last_y;
    out_word_t e;
    w = clamp(width_reg, 1, MAX_WIDTH_DEF);
    h = clamp(height_reg, 1, MAX_HEIGHT_DEF);
    b = clamp(bin_reg, 1, MAX_BIN_DEF);
    x = (col_pos >= w) ? 0 : col_pos;
    y = (row_pos >= h) ? 0 : row_pos;
    bc = x / b;
    br = y / b;
    low_sum[bc]  += int'(d.low_sample);
    high_sum[bc] += int'(d.high_sample);
    if (int'(d.max_sample) > peak_max[bc]) peak_max[bc] = int'(d.max_sample);
    last_x = (x + 1 == w);
    last_y = (y + 1 == h);
    if ((last_x || (x % b == b - 1)) && (last_y || (y % b == b - 1))) begin
      cw = w - bc * b;
      if (cw > b) cw = b;
      ch = h - br * b;
      if (ch > b) ch = b;
      cnt = cw * ch;
      lo_avg = low_sum[bc] / cnt;
      hi_avg = high_sum[bc] / cnt;
      e.bin_index   = 16'(br * ((w + b - 1) / b) + bc);
      e.avg_low     = lo_avg[15:0];
      e.avg_high    = hi_avg[15:0];
      e.peak        = peak_max[bc][14:0];
      e.pixel_count = cnt[8:0];
      e.frame_done  = last_x && last_y;
      expected_bins.push_back(e);
      low_sum[bc]  = 0;
      high_sum[bc] = 0;
      peak_max[bc] = 0;
    end
    if (last_x) begin
      col_pos = 0;
      row_pos = last_y ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endfunction

  function void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    bins_seen  = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      bin_reg    = BIN_FACTOR_RST;
      restart_frame();
      expected_bins.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_FRAME_WIDTH: begin
            width_reg = cfg_pwdata[8:0];
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_pwdata[8:0];
            restart_frame();
          end
          REG_BIN_FACTOR: begin
            bin_reg = cfg_pwdata[4:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) bin_pixel(in_data);
      if (out_valid && out_ready) begin
        bins_seen++;
        if (expected_bins.size() == 0) begin
          $display("%0t ns: unexpected output word, expected none, got %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_bins.pop_front();
          check_field("bin_index", e.bin_index, out_data.bin_index);
          check_field("avg_low", e.avg_low, out_data.avg_low);
          check_field("avg_high", e.avg_high, out_data.avg_high);
          check_field("peak", e.peak, out_data.peak);
          check_field("pixel_count", e.pixel_count, out_data.pixel_count);
          check_field("frame_done", e.frame_done, out_data.frame_done);
        end
      end
    end
    pending = expected_bins.size();
  end

endmodule

// File: tb/sv/pixel_block_binning_average_max_unit_test.sv
`timescale 1ns / 1ps
module pixel_block_binning_average_max_unit_test;
  import pbba_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending, bins_seen;
  int idle_mode = 0;
  int words_sent = 0;
  int idle_run = 0;
  bit hold_req = 1'b0;

  pixel_block_binning_average_max_unit i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  pbba_bin_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending, .bins_seen
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      idle_run <= 0;
    else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: stalls by phase, and holds off for a long stretch when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (idle_mode == 2) out_ready <= ($urandom_range(99) >= 80);
      else if (idle_mode == 3) out_ready <= ($urandom_range(99) >= 11);
      else out_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] sample_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [15:0] lo, logic [15:0] hi, logic [15:0] mx);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 80 : ((idle_mode == 3) ? 11 : 0);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{low_sample: lo, high_sample: hi, max_sample: mx};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  int cfg_w[12] = '{7, 1, 511, 16, 5, 0, 10, 3, 13, 256, 2, 9};
  int cfg_h[12] = '{5, 1, 3, 16, 3, 0, 9, 20, 11, 2, 300, 4};
  int cfg_b[12] = '{3, 1, 31, 16, 1, 0, 4, 7, 2, 16, 1, 5};

  initial begin
    int n;
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: one bin per pixel, so every extreme shows up directly.
    for (int i = 0; i < 16; i++) send_word(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4]);
    drain();
    cfg_write(REG_UNUSED, 32'hffff_ffff);

    for (int p = 0; p < 12; p++) begin
      drain();
      idle_mode = p % 4;
      cfg_write(REG_FRAME_WIDTH, {$urandom} << 9 | 32'(cfg_w[p]));
      cfg_write(REG_FRAME_HEIGHT, {$urandom} << 9 | 32'(cfg_h[p]));
      cfg_write(REG_BIN_FACTOR, {$urandom} << 5 | 32'(cfg_b[p]));
      n = 110 + $urandom_range(60);
      for (int i = 0; i < n; i++) begin
        if (p == 4 && i == 20) hold_req = 1'b1;
        if (i == n / 2 && p % 3 == 0) drain();
        if ($urandom_range(1)) send_word(16'($urandom), 16'($urandom), 16'($urandom));
        else send_word(sample_value(), sample_value(), sample_value());
      end
    end

    drain();
    $display("Sent %0d pixel words over 13 frame settings, including clamped registers;",
             words_sent);
    $display("%0d bin words checked under varied stalls and a long output hold-off.", bins_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
